FILE: hdl/bldc_pkg.sv
// Shared types, constants and lookup functions for the six-step commutator.
// Depends on nothing; used by bldc_div, the top level and the port checker.
package bldc_pkg;

  localparam int HIST_DEPTH = 10;               // hall history length, 4..16
  localparam int HALL_W     = 3;
  localparam int DESIRED_W  = 8;
  localparam int DUTY_W     = 7;
  localparam int SPEED_W    = 10;
  localparam int DRIVE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IDX_W      = 3;                // commutation step 0..5
  localparam int STEPS      = 6;

  // Dividend is desired * 6, divisor is a history age below HIST_DEPTH.
  localparam int DIVIDEND_W = DESIRED_W + 3;
  localparam int DIVISOR_W  = $clog2(HIST_DEPTH);
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [DUTY_W-1:0] DUTY_LIMIT = DUTY_W'(100);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DESIRED   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY  = CFG_IDX_W'(2);

  // Phase drive codes
  localparam logic [DRIVE_W-1:0] DRV_FLOAT = 2'd0;
  localparam logic [DRIVE_W-1:0] DRV_HIGH  = 2'd1;
  localparam logic [DRIVE_W-1:0] DRV_LOW   = 2'd2;

  typedef struct packed {
    logic [HALL_W-1:0] hall_code;
    logic              stop_request;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_u;
    logic [DRIVE_W-1:0] drive_v;
    logic [DRIVE_W-1:0] drive_w;
    logic [DUTY_W-1:0]  duty_percent;
    logic               shut_down;
    logic [SPEED_W-1:0] speed_estimate;
  } out_item_t;

  // Hall sequence value for a commutation step.
  function automatic logic [HALL_W-1:0] seq_value(input logic ccw,
                                                  input logic [IDX_W-1:0] idx);
    logic [HALL_W-1:0] v;
    begin
      unique case (idx)
        3'd0:    v = ccw ? 3'd2 : 3'd6;
        3'd1:    v = ccw ? 3'd3 : 3'd4;
        3'd2:    v = ccw ? 3'd1 : 3'd5;
        3'd3:    v = ccw ? 3'd5 : 3'd1;
        3'd4:    v = ccw ? 3'd4 : 3'd3;
        3'd5:    v = ccw ? 3'd6 : 3'd2;
        default: v = ccw ? 3'd2 : 3'd6;
      endcase
      return v;
    end
  endfunction

  // Drive pattern {u, v, w} for a sequence value.
  function automatic logic [3*DRIVE_W-1:0] drive_pattern(input logic ccw,
                                                         input logic [HALL_W-1:0] sv);
    logic [3*DRIVE_W-1:0] p;
    begin
      if (!ccw) begin
        unique case (sv)
          3'd1:    p = {DRV_FLOAT, DRV_HIGH,  DRV_LOW};
          3'd2:    p = {DRV_HIGH,  DRV_LOW,   DRV_FLOAT};
          3'd3:    p = {DRV_HIGH,  DRV_FLOAT, DRV_LOW};
          3'd4:    p = {DRV_LOW,   DRV_FLOAT, DRV_HIGH};
          3'd5:    p = {DRV_LOW,   DRV_HIGH,  DRV_FLOAT};
          3'd6:    p = {DRV_FLOAT, DRV_LOW,   DRV_HIGH};
          default: p = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
        endcase
      end else begin
        unique case (sv)
          3'd1:    p = {DRV_FLOAT, DRV_LOW,   DRV_HIGH};
          3'd2:    p = {DRV_LOW,   DRV_HIGH,  DRV_FLOAT};
          3'd3:    p = {DRV_LOW,   DRV_FLOAT, DRV_HIGH};
          3'd4:    p = {DRV_HIGH,  DRV_FLOAT, DRV_LOW};
          3'd5:    p = {DRV_HIGH,  DRV_LOW,   DRV_FLOAT};
          3'd6:    p = {DRV_FLOAT, DRV_HIGH,  DRV_LOW};
          default: p = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
        endcase
      end
      return p;
    end
  endfunction

endpackage

FILE: hdl/bldc_six_step_commutator_top.sv
// Six-step commutator top level: step logic, hall history and output register.
// Depends on bldc_pkg and bldc_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item): one item per commutation
//   tick, carrying the sampled hall code and a stop request. An item is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_item): one result item per
//   input item, with the U/V/W drive codes, duty, shutdown flag and the speed
//   estimate register. A stalled result holds in the output register.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 direction, 1 desired speed, 2 max duty); write only when
//   the block is idle.
// Flow:
//   An item that needs no speed update is staged at the edge that takes it
//   and moves into the output register when that is free. When a history
//   slot matches, the speed divide runs bit-serially, one quotient bit per
//   cycle, into the speed register before the result is loaded. One item is
//   in work at a time, so the input takes no new item until the last result
//   has moved into the output register. A result waiting in the output
//   register does not block the next item from being taken.
// Reset: clears the sequence step, hall history, shutdown latch and speed
//   register, and loads direction 0, desired speed 0 and max duty 50.
// Stall: while out_stall is high with out_valid set, a finished result waits in its
//   stage and the output register holds; the input stalls until the result moves on.
module bldc_six_step_commutator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bldc_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bldc_pkg::out_item_t            out_item,
  input  logic                           cfg_wr_en,
  input  logic [bldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bldc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bldc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Configuration registers
  logic                 direction_ccw;
  logic [DESIRED_W-1:0] desired_speed;
  logic [DUTY_W-1:0]    max_duty;

  // Block state
  logic [1:0]           state;
  logic [IDX_W-1:0]     seq_index;
  logic [HALL_W-1:0]    hall_hist [HIST_DEPTH];   // index = age, 0 newest
  logic                 shutdown_latch;
  logic [SPEED_W-1:0]   speed_register;

  // Result waiting for the output register (speed added on load)
  logic [DRIVE_W-1:0]   res_drive_u;
  logic [DRIVE_W-1:0]   res_drive_v;
  logic [DRIVE_W-1:0]   res_drive_w;
  logic [DUTY_W-1:0]    res_duty;
  logic                 res_shut;

  // Step decode
  logic                  accept;
  logic                  latch_now;
  logic                  stall_hit;
  logic                  match_any;
  logic [DIVISOR_W-1:0]  match_age;
  logic [HALL_W-1:0]     seq_val;
  logic [3*DRIVE_W-1:0]  pattern;
  logic [DUTY_W-1:0]     duty_sat;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  div_start;
  logic                  div_done;
  logic [SPEED_W-1:0]    div_quotient;
  logic                  out_load;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign latch_now = shutdown_latch || in_item.stop_request;

  // After this item shifts in, old age a-1 becomes age a.
  assign stall_hit = (hall_hist[0] == in_item.hall_code) &&
                     (hall_hist[1] == in_item.hall_code);

  // Oldest matching age 2..HIST_DEPTH-1 wins.
  always_comb begin
    match_any = 1'b0;
    match_age = '0;
    for (int a = 2; a < HIST_DEPTH; a++) begin
      if (hall_hist[a-1] == in_item.hall_code) begin
        match_any = 1'b1;
        match_age = DIVISOR_W'(a);
      end
    end
  end

  assign seq_val  = seq_value(direction_ccw, seq_index);
  assign pattern  = drive_pattern(direction_ccw, seq_val);
  assign duty_sat = (max_duty > DUTY_LIMIT) ? DUTY_LIMIT : max_duty;

  // desired * 6; a stall clears desired before the speed update
  assign dividend  = stall_hit ? '0 :
                     ({1'b0, desired_speed, 2'b00} + {2'b00, desired_speed, 1'b0});
  assign div_start = accept && !latch_now && match_any;

  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  bldc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (match_age),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      direction_ccw  <= 1'b0;
      desired_speed  <= '0;
      max_duty       <= DUTY_W'(50);
      seq_index      <= '0;
      shutdown_latch <= 1'b0;
      speed_register <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hall_hist[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_DIRECTION: direction_ccw <= cfg_data[0];
          CFG_DESIRED:   desired_speed <= cfg_data;
          CFG_MAX_DUTY:  max_duty      <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (latch_now) begin
              // Shut down: float, clear desired, leave the rest alone.
              shutdown_latch <= 1'b1;
              desired_speed  <= '0;
              state          <= S_DONE;
            end else begin
              seq_index <= (seq_index >= IDX_W'(STEPS - 1)) ? '0 : seq_index + 1'b1;
              hall_hist[0] <= in_item.hall_code;
              for (int i = 1; i < HIST_DEPTH; i++) begin
                hall_hist[i] <= hall_hist[i-1];
              end
              if (stall_hit) begin
                shutdown_latch <= 1'b1;
                desired_speed  <= '0;
              end
              state <= match_any ? S_DIV : S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            speed_register <= div_quotient;
            state          <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result staging and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (latch_now || stall_hit) begin
        res_drive_u <= DRV_FLOAT;
        res_drive_v <= DRV_FLOAT;
        res_drive_w <= DRV_FLOAT;
        res_duty    <= '0;
        res_shut    <= 1'b1;
      end else begin
        res_drive_u <= pattern[3*DRIVE_W-1:2*DRIVE_W];
        res_drive_v <= pattern[2*DRIVE_W-1:DRIVE_W];
        res_drive_w <= pattern[DRIVE_W-1:0];
        res_duty    <= duty_sat;
        res_shut    <= 1'b0;
      end
    end
    if (out_load) begin
      out_item.drive_u        <= res_drive_u;
      out_item.drive_v        <= res_drive_v;
      out_item.drive_w        <= res_drive_w;
      out_item.duty_percent   <= res_duty;
      out_item.shut_down      <= res_shut;
      out_item.speed_estimate <= speed_register;
    end
  end

endmodule

FILE: hdl/bldc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bldc_pkg for the dividend and divisor widths.
module bldc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bldc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [bldc_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [bldc_pkg::SPEED_W-1:0]    quotient
);
  import bldc_pkg::*;

  logic                    busy;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [DIVIDEND_W-1:0]   num;
  logic [DIVIDEND_W-1:0]   quo;
  logic [DIVISOR_W-1:0]    rem;
  logic [DIVISOR_W-1:0]    dvs;
  logic [DIVISOR_W:0]      trial;
  logic                    qbit;
  logic [DIVISOR_W-1:0]    rem_next;

  // Bring down the next dividend bit; subtract when it fits.
  always_comb begin
    trial = {rem, num[DIVIDEND_W-1]};
    qbit  = (trial >= {1'b0, dvs});
    if (qbit) begin
      rem_next = DIVISOR_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CNT_W'(DIVIDEND_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[DIVIDEND_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[DIVIDEND_W-2:0], qbit};
    end
  end

  assign quotient = quo[SPEED_W-1:0];

endmodule

FILE: hdl/bldc_checker.sv
// Port-level checker for the six-step commutator, bound to the top level.
// Depends on bldc_pkg for the item types and drive codes.
module bldc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input bldc_pkg::out_item_t out_item
);
  import bldc_pkg::*;

  logic seen_shut;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_shut <= 1'b0;
    end else if (out_valid && !out_stall && out_item.shut_down) begin
      seen_shut <= 1'b1;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // Shutdown floats every phase at zero duty.
  a_shut_float: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.shut_down |->
      out_item.drive_u == DRV_FLOAT && out_item.drive_v == DRV_FLOAT &&
      out_item.drive_w == DRV_FLOAT && out_item.duty_percent == '0)
    else $error("shutdown item drives a phase");

  // Running: exactly one high side and one low side.
  a_run_pattern: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.shut_down |->
      $onehot({out_item.drive_u == DRV_HIGH, out_item.drive_v == DRV_HIGH,
               out_item.drive_w == DRV_HIGH}) &&
      $onehot({out_item.drive_u == DRV_LOW, out_item.drive_v == DRV_LOW,
               out_item.drive_w == DRV_LOW}) &&
      out_item.duty_percent <= DUTY_LIMIT)
    else $error("running item has a bad drive pattern");

  // Shutdown sticks until reset.
  a_shut_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_shut |-> out_item.shut_down)
    else $error("shutdown cleared without reset");

endmodule

bind bldc_six_step_commutator_top bldc_checker u_bldc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: tb/tb_bldc_six_step_commutator_top.sv
// Self-checking bench for the six-step commutator: a commutation scoreboard
// predicts every result item; tasks drive the tick and register ports, a process the result stall.
// Depends on bldc_pkg and the bldc_six_step_commutator_top RTL.
`timescale 1ns / 100ps

module tb_bldc_six_step_commutator_top;
  import bldc_pkg::*;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 24;    // above the slowest divide path
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 235;
  localparam int TAIL_ITEMS   = 12;
  localparam int MAX_REPORTS  = 40;

  // Hall code order for one electrical turn, and the drive {u, v, w} per code.
  localparam logic [HALL_W-1:0] CW_ORDER  [STEPS] = '{3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2};
  localparam logic [HALL_W-1:0] CCW_ORDER [STEPS] = '{3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd6};

  localparam logic [3*DRIVE_W-1:0] CW_DRIVE [8] = '{
    {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT},
    {DRV_FLOAT, DRV_HIGH,  DRV_LOW},
    {DRV_HIGH,  DRV_LOW,   DRV_FLOAT},
    {DRV_HIGH,  DRV_FLOAT, DRV_LOW},
    {DRV_LOW,   DRV_FLOAT, DRV_HIGH},
    {DRV_LOW,   DRV_HIGH,  DRV_FLOAT},
    {DRV_FLOAT, DRV_LOW,   DRV_HIGH},
    {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT}
  };

  localparam logic [3*DRIVE_W-1:0] CCW_DRIVE [8] = '{
    {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT},
    {DRV_FLOAT, DRV_LOW,   DRV_HIGH},
    {DRV_LOW,   DRV_HIGH,  DRV_FLOAT},
    {DRV_LOW,   DRV_FLOAT, DRV_HIGH},
    {DRV_HIGH,  DRV_FLOAT, DRV_LOW},
    {DRV_HIGH,  DRV_LOW,   DRV_FLOAT},
    {DRV_FLOAT, DRV_HIGH,  DRV_LOW},
    {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT}
  };

  // Commutation scoreboard: own copy of registers and state, and the queue of
  // drive results still owed by the block.
  class commutation_scoreboard;
    bit                 ccw;
    bit [DESIRED_W-1:0] desired;
    bit [DUTY_W-1:0]    duty_cap;
    int unsigned        step;
    bit [HALL_W-1:0]    hall_ring [HIST_DEPTH];
    int unsigned        ring_ptr;
    bit                 latched;
    bit [SPEED_W-1:0]   speed;

    out_item_t   owed_drives [$];
    int unsigned items_noted;
    int unsigned results_seen;
    int unsigned reg_writes;
    int unsigned mismatches;

    function new();
      ccw      = 1'b0;
      desired  = '0;
      duty_cap = DUTY_W'(50);
      step     = 0;
      foreach (hall_ring[i]) hall_ring[i] = '0;
      ring_ptr = 0;
      latched  = 1'b0;
      speed    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_DIRECTION: ccw      = data[0];
        CFG_DESIRED:   desired  = data[DESIRED_W-1:0];
        CFG_MAX_DUTY:  duty_cap = data[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the commutator by one tick and return the drive it should show.
    function out_item_t commutate(in_item_t it);
      out_item_t       o;
      logic [HALL_W-1:0] hall;
      logic [HALL_W-1:0] seq_code;
      int unsigned     p;
      hall = it.hall_code;
      o    = '0;
      if (it.stop_request) latched = 1'b1;
      if (!latched) begin
        seq_code = ccw ? CCW_ORDER[step] : CW_ORDER[step];
        step     = (step + 1) % STEPS;
        p        = ring_ptr;
        hall_ring[p] = hall;
        // Same code three ticks running: the rotor is stuck, drop the drive.
        if (hall_ring[(p + HIST_DEPTH - 1) % HIST_DEPTH] == hall &&
            hall_ring[(p + HIST_DEPTH - 2) % HIST_DEPTH] == hall) begin
          latched = 1'b1;
          desired = '0;
        end
        // Oldest matching slot wins, so scan from newest to oldest.
        for (int k = HIST_DEPTH - 2; k > 0; k--) begin
          if (hall_ring[(p + k) % HIST_DEPTH] == hall)
            speed = SPEED_W'((int'(desired) * 6) / (HIST_DEPTH - k));
        end
        ring_ptr = (p + 1) % HIST_DEPTH;
        if (!latched) begin
          {o.drive_u, o.drive_v, o.drive_w} = ccw ? CCW_DRIVE[seq_code] : CW_DRIVE[seq_code];
          o.duty_percent = (duty_cap > DUTY_LIMIT) ? DUTY_LIMIT : duty_cap;
        end
      end
      if (latched) begin
        desired        = '0;
        o.drive_u      = DRV_FLOAT;
        o.drive_v      = DRV_FLOAT;
        o.drive_w      = DRV_FLOAT;
        o.duty_percent = '0;
      end
      o.shut_down      = latched;
      o.speed_estimate = speed;
      return o;
    endfunction

    function void note_input(in_item_t it);
      items_noted++;
      owed_drives.push_back(commutate(it));
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (owed_drives.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing owed", results_seen));
      end else begin
        want = owed_drives.pop_front();
        if (got.drive_u !== want.drive_u)
          flag_mismatch($sformatf("result %0d drive_u %0d, want %0d",
                                  results_seen, got.drive_u, want.drive_u));
        if (got.drive_v !== want.drive_v)
          flag_mismatch($sformatf("result %0d drive_v %0d, want %0d",
                                  results_seen, got.drive_v, want.drive_v));
        if (got.drive_w !== want.drive_w)
          flag_mismatch($sformatf("result %0d drive_w %0d, want %0d",
                                  results_seen, got.drive_w, want.drive_w));
        if (got.duty_percent !== want.duty_percent)
          flag_mismatch($sformatf("result %0d duty_percent %0d, want %0d",
                                  results_seen, got.duty_percent, want.duty_percent));
        if (got.shut_down !== want.shut_down)
          flag_mismatch($sformatf("result %0d shut_down %0d, want %0d",
                                  results_seen, got.shut_down, want.shut_down));
        if (got.speed_estimate !== want.speed_estimate)
          flag_mismatch($sformatf("result %0d speed_estimate %0d, want %0d",
                                  results_seen, got.speed_estimate, want.speed_estimate));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  commutation_scoreboard sb;

  // Both sides idle in bursts while this is set; cleared for calm stretches.
  bit                idling = 1'b1;
  // Rotor model for the stimulus, plus the last two codes the block stored.
  int unsigned       rot_pos;
  bit                rot_back;
  logic [HALL_W-1:0] prev1 = '0;
  logic [HALL_W-1:0] prev2 = '0;
  int unsigned       cycles = 0;

  bldc_six_step_commutator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge. A result can never leave on
  // the edge that takes its own tick, so checking before noting is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (in_valid && !in_stall) sb.note_input(in_item);
    end
  end

  // Result side: hold off the block in random bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (idling && !rst && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Guard against a hung block.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d results still owed",
             cycles, sb.owed_drives.size());
    $display("FAIL");
    $finish;
  end

  // Offer one tick and hold it until taken; an idle burst may come first,
  // with junk on the payload while valid is low.
  task automatic send_tick(logic [HALL_W-1:0] hall, logic stop);
    int unsigned gap;
    in_item_t    it;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    it.hall_code    = hall;
    it.stop_request = stop;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      in_item  = in_item_t'(4'($urandom));
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    prev2 = prev1;
    prev1 = hall;
  endtask

  // Drop valid and wait until every owed result has left the block.
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Set all three registers; the unused upper data bits carry junk.
  task automatic set_motor(bit dir, logic [DESIRED_W-1:0] want_speed,
                           logic [DUTY_W-1:0] duty);
    write_reg(CFG_DIRECTION, {7'($urandom), dir});
    write_reg(CFG_DESIRED, want_speed);
    write_reg(CFG_MAX_DUTY, {1'($urandom), duty});
  endtask

  // Mostly a turning rotor (step, hold, skip, reverse), some raw noise, and
  // never a third equal code in a row, which would latch shutdown early.
  function automatic logic [HALL_W-1:0] next_hall();
    int unsigned       r;
    logic [HALL_W-1:0] h;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      h = HALL_W'($urandom_range(0, 7));
    end else begin
      if (r < 16) ;
      else if (r < 20) rot_pos = (rot_pos + (rot_back ? 4 : 2)) % STEPS;
      else if (r < 23) rot_back = ~rot_back;
      else rot_pos = (rot_pos + (rot_back ? 5 : 1)) % STEPS;
      h = CW_ORDER[rot_pos];
    end
    if (h == prev1 && h == prev2) h = h ^ HALL_W'($urandom_range(1, 7));
    return h;
  endfunction

  initial begin
    logic [DESIRED_W-1:0] want_speed;
    logic [DUTY_W-1:0]    duty;
    sb       = new();
    rot_pos  = $urandom_range(0, STEPS - 1);
    rot_back = 1'($urandom);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a few ticks on the reset registers, speed stays at zero.
    send_tick(3'd6, 1'b0);
    send_tick(3'd4, 1'b0);
    send_tick(3'd5, 1'b0);
    drain_block();

    // Full speed byte, duty above the cap; one full turn so codes recur,
    // then a held code and the two invalid codes.
    set_motor(1'b0, 8'd255, 7'd127);
    send_tick(3'd1, 1'b0);
    send_tick(3'd3, 1'b0);
    send_tick(3'd2, 1'b0);
    send_tick(3'd6, 1'b0);
    send_tick(3'd4, 1'b0);
    send_tick(3'd5, 1'b0);
    send_tick(3'd1, 1'b0);
    send_tick(3'd7, 1'b0);
    send_tick(3'd7, 1'b0);
    send_tick(3'd0, 1'b0);
    send_tick(3'd7, 1'b0);
    drain_block();

    // Reverse sequence, smallest speed, zero duty; the spare index is ignored.
    set_motor(1'b1, 8'd1, 7'd0);
    write_reg(CFG_SPARE, 8'($urandom));
    send_tick(3'd2, 1'b0);
    send_tick(3'd3, 1'b0);
    send_tick(3'd1, 1'b0);
    send_tick(3'd5, 1'b0);
    send_tick(3'd4, 1'b0);
    send_tick(3'd6, 1'b0);
    send_tick(3'd2, 1'b0);
    send_tick(3'd0, 1'b0);
    drain_block();

    // Duty exactly at the cap.
    write_reg(CFG_MAX_DUTY, 8'd100);
    write_reg(CFG_DESIRED, 8'd200);
    send_tick(3'd6, 1'b0);
    send_tick(3'd5, 1'b0);
    drain_block();

    // Random phases, each on its own register setting; force the extremes early.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin want_speed = 8'd0;   duty = 7'd100; end
        1:       begin want_speed = 8'd255; duty = 7'd0;   end
        2:       begin want_speed = 8'd255; duty = 7'd127; end
        default: begin
          want_speed = 8'($urandom);
          duty       = 7'($urandom_range(0, 127));
        end
      endcase
      // Some phases run calm, with no idle bursts, and the last one is calm throughout.
      idling = (p % 3 != 2) && (p != PHASES - 1);
      set_motor(1'(p), want_speed, duty);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Pause the sender mid-phase until the block has caught up.
        if (i == PHASE_ITEMS / 2) drain_block();
        send_tick(next_hall(), 1'b0);
      end
      drain_block();
    end

    // Stall the rotor: the same code three times latches shutdown. After
    // that every tick, stop requests included, must show a floating bridge.
    send_tick(prev1, 1'b0);
    send_tick(prev1, 1'b0);
    for (int i = 0; i < TAIL_ITEMS; i++)
      send_tick(HALL_W'($urandom_range(0, 7)), (i == 2) ? 1'b1 : 1'($urandom));
    drain_block();
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("run covered %0d ticks and %0d register writes over %0d phases",
             sb.items_noted, sb.reg_writes, PHASES + 4);
    $display("%0d results compared, %0d mismatches, shutdown latched: %0d",
             sb.results_seen, sb.mismatches, sb.latched);
    if (sb.mismatches == 0 && sb.owed_drives.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
